[rtl/bandlimited_sinc_pulse_oscillator_top_assert.svh]
// assertion macros for the sinc pulse oscillator
`ifndef BANDLIMITED_SINC_PULSE_OSCILLATOR_TOP_ASSERT_SVH
`define BANDLIMITED_SINC_PULSE_OSCILLATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsp assertion failed");

// next-cycle implication
`define BSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsp assertion failed");

`endif

[rtl/bsp_pkg.sv]
// shared types, constants and rounding helpers for the sinc pulse oscillator
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int DW = 64;
    localparam int CW = $clog2(DW);
    localparam int ADDR_W = 4;
    localparam int PHASE_BITS_DEF = 40;
    localparam int SAMPLE_BITS_DEF = 18;

    localparam logic [DW-1:0] HALFPI_Q40 = 64'd1727108826179;
    localparam logic [DW-1:0] PI_Q32 = 64'd13493037705;
    localparam logic [DW-1:0] INV2PI_Q32 = 64'd683565276;
    localparam logic [DW-1:0] EPS_Q40 = 64'd34769605;
    localparam logic [DW-1:0] POLY_A = 64'd1686629713;
    localparam logic [DW-1:0] POLY_B = 64'd693598563;
    localparam logic [DW-1:0] POLY_C = 64'd85569278;
    localparam logic [DW-1:0] POLY_D = 64'd5026957;

    localparam logic [15:0] MOD_MIN = 16'd41;
    localparam logic [23:0] PERIOD_MIN = 24'd512;
    localparam logic [15:0] AMP_RESET = 16'd32768;
    localparam logic [23:0] PERIOD_RESET = 24'd25600;
    localparam logic [15:0] MOD_RESET = 16'd4096;

    localparam logic [1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_MODULATION = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_REFLECT,
        ST_REC,
        ST_HP,
        ST_DC,
        ST_HPL,
        ST_Q,
        ST_STEP,
        ST_NEG,
        ST_SIN_MOD,
        ST_SIN_TURN,
        ST_SIN_X2,
        ST_SIN_T1,
        ST_SIN_T2,
        ST_SIN_T3,
        ST_SIN_S,
        ST_SIN_AMP,
        ST_QUO,
        ST_OUT
    } state_t;

    // round half up of a non-negative value, shift right by n
    function automatic logic [DW-1:0] urnd(input logic [DW-1:0] v, input int unsigned n);
        logic [DW-1:0] half;
        half = 64'd1 << (n - 1);
        return (v + half) >> n;
    endfunction

    // round half away from zero
    function automatic logic signed [DW-1:0] srnd(input logic signed [DW-1:0] v,
                                                  input int unsigned n);
        logic [DW-1:0] mag;
        logic [DW-1:0] r;
        mag = v[DW-1] ? -v : v;
        r = urnd(mag, n);
        return v[DW-1] ? -$signed(r) : $signed(r);
    endfunction

    // clamp to a signed range of the given width
    function automatic logic signed [DW-1:0] sat(input logic signed [DW-1:0] v,
                                                 input int unsigned bits);
        logic signed [DW-1:0] lim;
        lim = 64'sd1 <<< (bits - 1);
        if (v > lim - 64'sd1)
        begin
            return lim - 64'sd1;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

endpackage

[rtl/bandlimited_sinc_pulse_oscillator_top.sv]
// sinc pulse train oscillator: sequencer, state and configuration registers
//
//   channel   direction   handshake              payload
//   in        to block    in_valid / in_ready    tick
//   out       from block  out_valid / out_ready  sample, period_start
//   cfg       to block    psel / penable         paddr, pwdata, prdata
//
// an ordinary sample takes one serial multiply for the sine recurrence and one
// division for sine over phase, skipped when the phase is near zero
// a sample that starts a period runs the period set-up and three sine
// evaluations, which share the same multiplier and divider
// rst_n clears the sequencer, phase, step and dc level and resets the registers
// a new tick is taken while the last sample still waits in the output register
`timescale 1ns / 1ps
`include "bandlimited_sinc_pulse_oscillator_top_assert.svh"

module bandlimited_sinc_pulse_oscillator_top
    import bsp_pkg::*;
#(
    parameter int PHASE_BITS  = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          tick,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          period_start
);

    localparam int FRAC_BITS = PHASE_BITS - 22;
    localparam int STEP_BITS = PHASE_BITS - 8;
    localparam int SH_DN = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
    localparam int SH_UP = (FRAC_BITS >= 28) ? 0 : 28 - FRAC_BITS;
    localparam logic signed [DW-1:0] TWO_PI_F = urnd(HALFPI_Q40 << 2, 40 - FRAC_BITS);
    localparam logic signed [DW-1:0] HALF_PI_F = urnd(HALFPI_Q40, 40 - FRAC_BITS);
    localparam logic signed [DW-1:0] QUARTER_PI_F = urnd(HALFPI_Q40, 41 - FRAC_BITS);
    localparam logic [DW-1:0] EPS_F = urnd(EPS_Q40, 40 - FRAC_BITS);

    state_t state_reg;
    state_t state_next;
    logic   launched_reg;

    logic [15:0] amp_reg;
    logic [23:0] period_reg;
    logic [15:0] mod_reg;

    logic signed [PHASE_BITS-1:0]  phase_reg;
    logic signed [STEP_BITS-1:0]   step_reg;
    logic signed [PHASE_BITS-1:0]  hpl_reg;
    logic signed [23:0]            dc_reg;
    logic signed [23:0]            sine_now_reg;
    logic signed [23:0]            sine_before_reg;
    logic signed [23:0]            gain_reg;
    logic [39:0]                   hp_reg;
    logic [20:0]                   d_reg;
    logic [31:0]                   q_reg;
    logic [1:0]                    sin_idx_reg;
    logic [31:0]                   r28_reg;
    logic [1:0]                    quad_reg;
    logic [30:0]                   x_reg;
    logic [30:0]                   x2_reg;
    logic [31:0]                   t_reg;
    logic                          start_flag_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          out_valid_reg;
    logic                          out_start_reg;

    logic          mul_start;
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic          mul_done;
    logic [DW-1:0] mul_p;
    logic          div_start;
    logic [DW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [DW-1:0] div_rem;
    logic          op_done;

    logic                 cfg_write;
    logic signed [DW-1:0] phase_w;
    logic signed [DW-1:0] step_w;
    logic signed [DW-1:0] hpl_w;
    logic signed [DW-1:0] adv_phase;
    logic signed [DW-1:0] refl_phase;
    logic [DW-1:0]        phase_mag;
    logic                 near_zero;
    logic signed [DW-1:0] sin_arg;
    logic [DW-1:0]        arg_mag;
    logic [DW-1:0]        sine_mag;
    logic [DW-1:0]        gain_mag;
    logic [DW-1:0]        hp_n;
    logic [20:0]          d_calc;
    logic [DW-1:0]        mod_r;
    logic [DW-1:0]        r28_calc;
    logic [31:0]          turn;
    logic [31:0]          s_calc;
    logic signed [DW-1:0] s_w;
    logic signed [DW-1:0] gain_calc;
    logic [DW-1:0]        amp_v;
    logic signed [DW-1:0] amp_calc;
    logic signed [DW-1:0] rec_v;
    logic signed [DW-1:0] rec_calc;
    logic signed [DW-1:0] q22;
    logic signed [DW-1:0] smp_calc;

    bsp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    bsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign op_done   = mul_done | div_done;
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_AMPLITUDE:  prdata = {16'd0, amp_reg};
            REG_PERIOD:     prdata = {8'd0, period_reg};
            REG_MODULATION: prdata = {16'd0, mod_reg};
            default:        prdata = '0;
        endcase
    end

    // datapath arithmetic around the shared units
    always_comb
    begin
        phase_w    = DW'(phase_reg);
        step_w     = DW'(step_reg);
        hpl_w      = DW'(hpl_reg);
        adv_phase  = sat(phase_w + step_w, PHASE_BITS);
        refl_phase = sat((hpl_w <<< 1) - phase_w, PHASE_BITS);
        phase_mag  = phase_w[DW-1] ? -phase_w : phase_w;
        near_zero  = phase_mag <= EPS_F;

        case (sin_idx_reg)
            2'd0:    sin_arg = phase_w;
            2'd1:    sin_arg = phase_w - step_w;
            default: sin_arg = step_w + HALF_PI_F;
        endcase
        arg_mag  = sin_arg[DW-1] ? -sin_arg : sin_arg;
        sine_mag = sine_now_reg[23] ? -DW'(sine_now_reg) : DW'(sine_now_reg);
        gain_mag = gain_reg[23] ? -DW'(gain_reg) : DW'(gain_reg);

        hp_n   = (mul_p + (64'd1 << 20)) >> 21;
        d_calc = (hp_n == '0) ? 21'd1 : 21'((hp_n << 1) - 64'd1);

        // reduce into [0, 2pi) from the magnitude remainder
        mod_r    = (sin_arg[DW-1] && (div_rem != '0)) ? TWO_PI_F - div_rem : div_rem;
        r28_calc = (mod_r >> SH_DN) << SH_UP;
        turn     = mul_p[59:28];

        s_calc    = mul_p[61:30];
        s_w       = quad_reg[1] ? -$signed(DW'(s_calc)) : $signed(DW'(s_calc));
        gain_calc = sat(srnd(s_w <<< 1, 9), 24);
        amp_v     = urnd(mul_p, 24);
        amp_calc  = sat(quad_reg[1] ? -$signed(amp_v) : $signed(amp_v), 24);

        rec_v    = (gain_reg[23] ^ sine_now_reg[23]) ? -$signed(mul_p) : $signed(mul_p);
        rec_calc = sat(srnd(rec_v, 21) - DW'(sine_before_reg), 24);

        if (near_zero)
        begin
            q22 = $signed(DW'(amp_reg) << 6);
        end
        else
        begin
            q22 = (sine_now_reg[23] ^ phase_reg[PHASE_BITS-1]) ? -$signed(div_quo)
                                                              : $signed(div_quo);
        end
        smp_calc = sat(srnd(q22 - DW'(dc_reg), 6), SAMPLE_BITS);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && tick)
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:  state_next = (adv_phase <= QUARTER_PI_F) ? ST_HP : ST_REFLECT;
            ST_REFLECT:  state_next = ST_REC;
            ST_REC:      state_next = op_done ? ST_QUO : ST_REC;
            ST_HP:       state_next = op_done ? ST_DC : ST_HP;
            ST_DC:       state_next = op_done ? ST_HPL : ST_DC;
            ST_HPL:      state_next = op_done ? ST_Q : ST_HPL;
            ST_Q:        state_next = op_done ? ST_STEP : ST_Q;
            ST_STEP:     state_next = op_done ? ST_NEG : ST_STEP;
            ST_NEG:      state_next = ST_SIN_MOD;
            ST_SIN_MOD:  state_next = op_done ? ST_SIN_TURN : ST_SIN_MOD;
            ST_SIN_TURN: state_next = op_done ? ST_SIN_X2 : ST_SIN_TURN;
            ST_SIN_X2:   state_next = op_done ? ST_SIN_T1 : ST_SIN_X2;
            ST_SIN_T1:   state_next = op_done ? ST_SIN_T2 : ST_SIN_T1;
            ST_SIN_T2:   state_next = op_done ? ST_SIN_T3 : ST_SIN_T2;
            ST_SIN_T3:   state_next = op_done ? ST_SIN_S : ST_SIN_T3;
            ST_SIN_S:
            begin
                if (op_done)
                begin
                    state_next = (sin_idx_reg == 2'd2) ? ST_QUO : ST_SIN_AMP;
                end
            end
            ST_SIN_AMP:  state_next = op_done ? ST_SIN_MOD : ST_SIN_AMP;
            ST_QUO:
            begin
                if (near_zero || op_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit launches and operand selection
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_REC:
            begin
                mul_start = !launched_reg;
                mul_a     = gain_mag;
                mul_b     = sine_mag;
            end
            ST_HP:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(period_reg);
                mul_b     = DW'(mod_reg);
            end
            ST_DC:
            begin
                div_start = !launched_reg;
                div_num   = (DW'(amp_reg) << 6) + DW'(d_reg >> 1);
                div_den   = DW'(d_reg);
            end
            ST_HPL:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(d_reg);
                mul_b     = HALFPI_Q40;
            end
            ST_Q:
            begin
                div_start = !launched_reg;
                div_num   = DW'(d_reg) << 40;
                div_den   = DW'(hp_reg);
            end
            ST_STEP:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(q_reg);
                mul_b     = PI_Q32;
            end
            ST_SIN_MOD:
            begin
                div_start = !launched_reg;
                div_num   = arg_mag;
                div_den   = TWO_PI_F;
            end
            ST_SIN_TURN:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(r28_reg);
                mul_b     = INV2PI_Q32;
            end
            ST_SIN_X2:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(x_reg);
                mul_b     = DW'(x_reg);
            end
            ST_SIN_T1:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(x2_reg);
                mul_b     = POLY_D;
            end
            ST_SIN_T2, ST_SIN_T3:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(x2_reg);
                mul_b     = DW'(t_reg);
            end
            ST_SIN_S:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(x_reg);
                mul_b     = DW'(t_reg);
            end
            ST_SIN_AMP:
            begin
                mul_start = !launched_reg;
                mul_a     = DW'(amp_reg);
                mul_b     = DW'(t_reg);
            end
            ST_QUO:
            begin
                div_start = !launched_reg && !near_zero;
                div_num   = sine_mag << FRAC_BITS;
                div_den   = phase_mag;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            amp_reg       <= AMP_RESET;
            period_reg    <= PERIOD_RESET;
            mod_reg       <= MOD_RESET;
            phase_reg     <= '0;
            step_reg      <= '0;
            dc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start || div_start)
            begin
                launched_reg <= 1'b1;
            end
            else if (op_done)
            begin
                launched_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_AMPLITUDE:  amp_reg <= pwdata[15:0];
                    REG_PERIOD:
                    begin
                        period_reg <= (pwdata[23:0] < PERIOD_MIN) ? PERIOD_MIN : pwdata[23:0];
                    end
                    REG_MODULATION:
                    begin
                        mod_reg <= (pwdata[15:0] < MOD_MIN) ? MOD_MIN : pwdata[15:0];
                    end
                    default:        amp_reg <= amp_reg;
                endcase
            end

            case (state_reg)
                ST_ADVANCE: phase_reg <= adv_phase[PHASE_BITS-1:0];
                ST_REFLECT:
                begin
                    if (phase_w > hpl_w)
                    begin
                        phase_reg <= refl_phase[PHASE_BITS-1:0];
                        step_reg  <= -step_reg;
                    end
                end
                ST_DC:
                begin
                    if (op_done)
                    begin
                        dc_reg <= div_quo[23:0];
                    end
                end
                ST_STEP:
                begin
                    if (op_done)
                    begin
                        step_reg <= STEP_BITS'(urnd(mul_p, 52 - FRAC_BITS));
                    end
                end
                ST_NEG:     phase_reg <= -phase_reg;
                default:    phase_reg <= phase_reg;
            endcase

            if ((state_reg == ST_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_ADVANCE: start_flag_reg <= adv_phase <= QUARTER_PI_F;
            ST_REC:
            begin
                if (op_done)
                begin
                    sine_before_reg <= sine_now_reg;
                    sine_now_reg    <= rec_calc[23:0];
                end
            end
            ST_HP:
            begin
                if (op_done)
                begin
                    hp_reg <= mul_p[39:0];
                    d_reg  <= d_calc;
                end
            end
            ST_HPL:
            begin
                if (op_done)
                begin
                    hpl_reg <= PHASE_BITS'(urnd(mul_p, 40 - FRAC_BITS));
                end
            end
            ST_Q:
            begin
                if (op_done)
                begin
                    q_reg <= div_quo[31:0];
                end
            end
            ST_NEG:     sin_idx_reg <= 2'd0;
            ST_SIN_MOD:
            begin
                if (op_done)
                begin
                    r28_reg <= r28_calc[31:0];
                end
            end
            ST_SIN_TURN:
            begin
                if (op_done)
                begin
                    quad_reg <= turn[31:30];
                    // mirror odd quadrants about a quarter turn
                    x_reg    <= turn[30] ? (31'h4000_0000 - {1'b0, turn[29:0]})
                                         : {1'b0, turn[29:0]};
                end
            end
            ST_SIN_X2:
            begin
                if (op_done)
                begin
                    x2_reg <= mul_p[60:30];
                end
            end
            ST_SIN_T1:
            begin
                if (op_done)
                begin
                    t_reg <= 32'(POLY_C - (mul_p >> 30));
                end
            end
            ST_SIN_T2:
            begin
                if (op_done)
                begin
                    t_reg <= 32'(POLY_B - (mul_p >> 30));
                end
            end
            ST_SIN_T3:
            begin
                if (op_done)
                begin
                    t_reg <= 32'(POLY_A - (mul_p >> 30));
                end
            end
            ST_SIN_S:
            begin
                if (op_done)
                begin
                    t_reg <= s_calc;
                    if (sin_idx_reg == 2'd2)
                    begin
                        gain_reg <= gain_calc[23:0];
                    end
                end
            end
            ST_SIN_AMP:
            begin
                if (op_done)
                begin
                    if (sin_idx_reg == 2'd0)
                    begin
                        sine_now_reg <= amp_calc[23:0];
                    end
                    else
                    begin
                        sine_before_reg <= amp_calc[23:0];
                    end
                    sin_idx_reg <= sin_idx_reg + 2'd1;
                end
            end
            ST_QUO:
            begin
                if (near_zero || op_done)
                begin
                    res_reg <= smp_calc[SAMPLE_BITS-1:0];
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sample_reg    <= res_reg;
                    out_start_reg <= start_flag_reg;
                end
            end
            default:    sin_idx_reg <= sin_idx_reg;
        endcase
    end

    assign in_ready     = state_reg == ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign period_start = out_start_reg;

    `BSP_ASSERT_IMPL(a_done_launched, mul_done || div_done, launched_reg)
    `BSP_ASSERT_IMPL(a_units_exclusive, mul_done, !div_done)
    `BSP_ASSERT_NEXT(a_tick_advances, in_valid && in_ready && tick, state_reg == ST_ADVANCE)

endmodule

[rtl/bsp_mul.sv]
// bit-serial shift-add multiplier, low 64 bits of the product
`timescale 1ns / 1ps

module bsp_mul
    import bsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output logic          done,
    output logic [DW-1:0] product
);

    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] a_reg;
    logic [DW-1:0] b_reg;
    logic [DW-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one multiplier bit per cycle, stops early once the rest is zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/bsp_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bsp_div
    import bsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [DW-1:0] quo,
    output logic [DW-1:0] rem
);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out of the quotient register as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
